// ----- hw/rtl/spq_pkg.sv -----
// Shared types and constants of the sorted priority queue.
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMD_W = 2;
  localparam int VALUE_W = 32;
  localparam int RANK_W = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_PULL   = 2'd1,
    CMD_PEEK   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [RANK_W-1:0]  rank;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pull;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/spq_req_if.sv -----
// Request channel of the sorted priority queue.
interface spq_req_if;
  logic                              valid;
  logic                              ready;
  logic        [spq_pkg::CMD_W-1:0]   command;
  logic signed [spq_pkg::VALUE_W-1:0] payload;
  logic signed [spq_pkg::RANK_W-1:0]  rank;

  modport source (output valid, command, payload, rank, input ready);
  modport sink (input valid, command, payload, rank, output ready);
endinterface

// ----- hw/rtl/spq_rsp_if.sv -----
// Response channel of the sorted priority queue.
interface spq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [spq_pkg::VALUE_W-1:0]  front_value;
  logic        [spq_pkg::STATUS_W-1:0] status;
  logic        [spq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, front_value, status, occupancy, input ready);
  modport sink (input valid, front_value, status, occupancy, output ready);
endinterface

// ----- hw/rtl/sorted_priority_queue.sv -----
// Sorted priority queue built as a chain of compare-and-shift cells.
//
// The queue holds up to DEPTH entries ordered by descending signed rank, with
// equal ranks in arrival order. Every request (insert, pull, peek or another
// command) gives one response with front value, status and occupancy. A
// request is taken in every cycle in which the response is taken or absent:
// all cells compare the new rank and shift in parallel in the cycle of
// acceptance, and the response register is the only stage.
// Stored entries need no clearing after reset.
module sorted_priority_queue (
  input logic      clk,
  input logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    out_valid;
  logic signed [VALUE_W-1:0] out_value;
  status_t                 out_status;
  logic [OCC_W-1:0]        out_occupancy;
  logic                    accept;
  cell_ctrl_t              ctrl;
  status_t                 res_status;
  logic signed [VALUE_W-1:0] res_value;
  entry_t                  entries [DEPTH];
  logic [DEPTH-1:0]        ge;

  assign req.ready = !out_valid || rsp.ready;
  assign accept = req.valid && req.ready;

  always_comb begin
    ctrl.ins = 1'b0;
    ctrl.pull = 1'b0;
    ctrl.new_entry.value = req.payload;
    ctrl.new_entry.rank = req.rank;
    count_next = count;
    res_status = ST_OK;
    res_value = '0;
    if (accept) begin
      unique case (cmd_t'(req.command))
        CMD_INSERT: begin
          if (count == CNT_W'(DEPTH)) begin
            res_status = ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            count_next = count + 1'b1;
          end
        end
        CMD_PULL, CMD_PEEK: begin
          if (count == '0) begin
            res_status = ST_EMPTY;
          end else begin
            res_value = entries[0].value;
            if (cmd_t'(req.command) == CMD_PULL) begin
              ctrl.pull = 1'b1;
              count_next = count - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   occ;
    logic   left_ge;
    entry_t left_entry;
    entry_t right_entry;

    assign occ = CNT_W'(i) < count;
    if (i == 0) begin : g_head
      assign left_ge = 1'b1;
      assign left_entry = ctrl.new_entry;
    end else begin : g_body
      assign left_ge = ge[i-1];
      assign left_entry = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ),
      .left_ge     (left_ge),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .ge          (ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value <= res_value;
      out_status <= res_status;
      out_occupancy <= OCC_W'(count_next);
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.front_value = out_value;
  assign rsp.status = out_status;
  assign rsp.occupancy = out_occupancy;

endmodule

// ----- hw/rtl/spq_cell.sv -----
// One storage cell of the sorted chain, holding a single entry.
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  logic                left_ge,
  input  spq_pkg::entry_t     left_entry,
  input  spq_pkg::entry_t     right_entry,
  output spq_pkg::entry_t     entry,
  output logic                ge
);
  import spq_pkg::*;

  assign ge = occ && (entry.rank >= ctrl.new_entry.rank);

  // An insert keeps the prefix of equal or higher rank, writes the new
  // entry at the first cell past it, and shifts the rest one place back.
  always_ff @(posedge clk) begin
    if (ctrl.ins && !ge) begin
      entry <= left_ge ? ctrl.new_entry : left_entry;
    end else if (ctrl.pull) begin
      entry <= right_entry;
    end
  end

endmodule

// ----- hw/rtl/spq_checker.sv -----
// Port-level assertions for the sorted priority queue, bound to the top level.
module spq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [spq_pkg::VALUE_W-1:0]  rsp_front_value,
  input logic [spq_pkg::STATUS_W-1:0] rsp_status,
  input logic [spq_pkg::OCC_W-1:0]    rsp_occupancy
);
  import spq_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_front_value)
      && $stable(rsp_status) && $stable(rsp_occupancy))
    else $error("stalled response changed");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while response stalled");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EMPTY |-> rsp_occupancy == '0 && rsp_front_value == '0)
    else $error("empty status with entries or data");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == OCC_W'(DEPTH)
      && rsp_front_value == '0)
    else $error("full status without a full queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_front_value (rsp.front_value),
  .rsp_status      (rsp.status),
  .rsp_occupancy   (rsp.occupancy)
);

// ----- bench/spq_order_checker.sv -----
// Checker that predicts and compares every response of the sorted priority queue.
module spq_order_checker
  import spq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  spq_req_if   req,
  spq_rsp_if   rsp,
  output int   error_count,
  output int   pending,
  output int   checked_count,
  output int   full_count,
  output int   empty_count
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
    logic        [OCC_W-1:0]   occupancy;
  } response_t;

  entry_t    held [DEPTH];
  int        held_count;
  response_t awaited_responses [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // Entries stay sorted by descending rank, and a new entry goes behind every
  // entry of equal or higher rank.
  function automatic response_t next_response(input logic [CMD_W-1:0] command,
                                              input logic signed [VALUE_W-1:0] payload,
                                              input logic signed [RANK_W-1:0] rank);
    response_t result;
    int        pos;
    int        i;
    result = '{value: '0, status: ST_OK, occupancy: '0};
    case (command)
      CMD_INSERT: begin
        if (held_count >= DEPTH) begin
          result.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && $signed(held[pos].rank) >= rank) pos++;
          for (i = held_count; i > pos; i--) held[i] = held[i-1];
          held[pos] = '{value: payload, rank: rank};
          held_count++;
        end
      end
      CMD_PULL, CMD_PEEK: begin
        if (held_count == 0) begin
          result.status = ST_EMPTY;
        end else begin
          result.value = held[0].value;
          if (command == CMD_PULL) begin
            for (i = 1; i < held_count; i++) held[i-1] = held[i];
            held_count--;
          end
        end
      end
      default: ;
    endcase
    result.occupancy = OCC_W'(held_count);
    return result;
  endfunction

  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      held_count = 0;
      awaited_responses.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_responses.size() == 0) begin
          report_mismatch($sformatf("response with none awaited: value %0d status %0d count %0d",
                                    rsp.front_value, rsp.status, rsp.occupancy));
        end else begin
          want = awaited_responses.pop_front();
          checked_count++;
          if (rsp.front_value !== want.value)
            report_mismatch($sformatf("front value %0d, expected %0d",
                                      rsp.front_value, want.value));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
          if (rsp.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, expected %0d",
                                      rsp.occupancy, want.occupancy));
        end
      end
      if (req.valid && req.ready) begin
        want = next_response(req.command, req.payload, req.rank);
        if (want.status == ST_FULL) full_count++;
        if (want.status == ST_EMPTY) empty_count++;
        awaited_responses.push_back(want);
      end
    end
    pending = awaited_responses.size();
  end

endmodule

// ----- bench/tb_sorted_priority_queue.sv -----
// Testbench top of the sorted priority queue: clock, reset, requests and verdict.
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int TOTAL_ITEMS = 550;
  localparam int QUIET_FROM = 470;
  localparam int PRESSURE_AT = 200;
  localparam int HOLD_CYCLES = 60;

  logic clk;
  logic rst;
  bit   quiet_tail;
  bit   hold_off_pending;
  int   sent_count;
  int   error_count;
  int   pending;
  int   checked_count;
  int   full_count;
  int   empty_count;

  spq_req_if req ();
  spq_rsp_if rsp ();

  sorted_priority_queue i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  spq_order_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rsp           (rsp),
    .error_count   (error_count),
    .pending       (pending),
    .checked_count (checked_count),
    .full_count    (full_count),
    .empty_count   (empty_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #2_400_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_request(input logic [CMD_W-1:0] command,
                              input logic signed [VALUE_W-1:0] payload,
                              input logic signed [RANK_W-1:0] rank);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.command <= command;
    req.payload <= payload;
    req.rank    <= rank;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent_count++;
  endtask

  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    logic        [CMD_W-1:0]   command;
    logic signed [VALUE_W-1:0] payload;
    logic signed [RANK_W-1:0]  rank;
    int mode;
    int phase_len;
    int roll;
    int insert_pct;
    int pull_pct;
    int peek_pct;
    int drain;
    bit pressure_done;

    rst = 1'b1;
    req.valid   <= 1'b0;
    req.command <= CMD_INSERT;
    req.payload <= '0;
    req.rank    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_request(CMD_PULL, '0, '0);
    send_request(CMD_PEEK, '0, '0);
    send_request(CMD_NOP, '1, '1);
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 5)
        0: rank = 16'sh7fff;
        1: rank = 16'sh8000;
        2: rank = 16'sh0000;
        3: rank = 16'shffff;
        default: rank = 16'sh0001;
      endcase
      case (i)
        0: payload = 32'sh7fffffff;
        1: payload = 32'sh80000000;
        2: payload = 32'sh00000000;
        3: payload = 32'shffffffff;
        default: payload = $urandom;
      endcase
      send_request(CMD_INSERT, payload, rank);
    end
    send_request(CMD_INSERT, $urandom, 16'sh7fff);
    send_request(CMD_PEEK, '0, '0);
    send_request(CMD_NOP, '0, '0);
    send_request(CMD_PULL, '0, '0);

    pressure_done = 1'b0;
    while (sent_count < TOTAL_ITEMS) begin
      // Insert-heavy, pull-heavy and balanced phases drive the queue between
      // full and empty.
      mode = $urandom_range(0, 2);
      phase_len = $urandom_range(8, 40);
      case (mode)
        0: begin insert_pct = 70; pull_pct = 18; peek_pct = 9; end
        1: begin insert_pct = 20; pull_pct = 60; peek_pct = 15; end
        default: begin insert_pct = 45; pull_pct = 33; peek_pct = 17; end
      endcase
      if (!pressure_done && sent_count >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_off_pending = 1'b1;
        repeat (20) send_request(CMD_INSERT, $urandom, 16'($urandom));
      end
      for (int n = 0; n < phase_len && sent_count < TOTAL_ITEMS; n++) begin
        if (sent_count >= QUIET_FROM) quiet_tail = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct) command = CMD_INSERT;
        else if (roll < insert_pct + pull_pct) command = CMD_PULL;
        else if (roll < insert_pct + pull_pct + peek_pct) command = CMD_PEEK;
        else command = CMD_NOP;
        case ($urandom_range(0, 3))
          0, 1: rank = 16'(int'($urandom_range(0, 6)) - 3);
          2: rank = 16'($urandom);
          default: begin
            case ($urandom_range(0, 3))
              0: rank = 16'sh7fff;
              1: rank = 16'sh8000;
              2: rank = 16'sh0000;
              default: rank = 16'shffff;
            endcase
          end
        endcase
        payload = $urandom;
        send_request(command, payload, rank);
      end
    end
    req.valid <= 1'b0;

    drain = 0;
    while (pending != 0 && drain < 1000) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);
    if (pending != 0) $display("%0d responses never arrived", pending);

    $display("Sent %0d requests and checked %0d responses.", sent_count, checked_count);
    $display("Inserts met a full queue %0d times; pulls or peeks met an empty one %0d times.",
             full_count, empty_count);
    if (error_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/spq_pkg.sv
hw/rtl/spq_req_if.sv
hw/rtl/spq_rsp_if.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
hw/rtl/spq_checker.sv
bench/spq_order_checker.sv
bench/tb_sorted_priority_queue.sv
